FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is low
`define CEA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed");

// Clocked check that also runs through reset
`define CEA_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("check failed");

`endif

FILE: hdl/ceagm_pkg.sv
// ---------------------------------------------------------------------------
// ceagm_pkg
// Constants, controller states, datapath commands and status for the
// complete elliptic integral (AGM) block.
// ---------------------------------------------------------------------------
package ceagm_pkg;

    localparam int AGM_ITERATIONS = 16;
    localparam int N_W            = $clog2(AGM_ITERATIONS);

    localparam logic [63:0] PI_Q61       = 64'h6487_ED51_10B4_611A;
    localparam logic [31:0] HALF_PI_Q31  = 32'd3373259426;
    localparam logic [29:0] SERIES_LIMIT = 30'd1074;
    localparam logic [62:0] ONE_Q62      = {1'b1, 62'd0};
    localparam logic [63:0] QUARTER_Q62  = 64'h1000_0000_0000_0000;
    localparam logic [63:0] DK_MAX       = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] DE_MAG_MAX   = 64'h0000_0000_8000_0000;
    localparam logic [63:0] QUOT_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [6:0]  DK_SHIFT     = 7'd55;
    localparam logic [6:0]  DE_SHIFT     = 7'd28;
    localparam logic [6:0]  NO_SHIFT     = 7'd0;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_B0_START, ST_B0_WAIT, ST_AB, ST_SQ_START, ST_SQ_WAIT,
        ST_K_START, ST_K_WAIT, ST_E_LO, ST_E_HI, ST_E_FIN,
        ST_SER0, ST_SER1, ST_SER2, ST_SER3,
        ST_OMK_LO, ST_OMK_HI, ST_OMK_FIN, ST_DEN,
        ST_DK_START, ST_DK_WAIT, ST_DE_START, ST_DE_WAIT, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_B0_START, OP_B0_SET, OP_AB, OP_SQ_START, OP_SQ_SET,
        OP_K_START, OP_K_SET, OP_E_LO, OP_E_HI, OP_E_SET,
        OP_SER0, OP_SER1, OP_SER2, OP_SER3,
        OP_OMK_LO, OP_OMK_HI, OP_OMK_SET, OP_DEN,
        OP_DK_START, OP_DK_SET, OP_DE_START, OP_DE_SET, OP_OUT
    } t_dp_op;

    typedef struct packed {
        logic inf;
        logic series;
        logic last_round;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: hdl/complete_elliptic_integrals_agm.sv
// ---------------------------------------------------------------------------
// complete_elliptic_integrals_agm
// K(m), E(m), dK/dm and dE/dm by the arithmetic-geometric mean, in fixed
// point, one result beat per input beat.
// ---------------------------------------------------------------------------
// Channel  Dir  Width  Contents
// s_axis   in   32     tdata: param_m
// m_axis   out  144/1  tdata: k_value, e_value, dk_dm, de_dm; tuser: k_infinite
//
// An item with m >= 1 only passes accept, check and output. Otherwise the AGM runs
// R rounds (1 to AGM_ITERATIONS-1), then K, E and either the series or the exact
// derivatives; the block waits on each square root and on each division (shift
// 0, 55 or 28) in turn.
// Reset is synchronous, active low; no memory to clear.
// Input is taken again while a finished result still waits on m_axis.
// ---------------------------------------------------------------------------
module complete_elliptic_integrals_agm (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [31:0]  i_s_axis_tdata,   // [31:0] param_m
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [143:0] o_m_axis_tdata,   // k_value, e_value, dk_dm, de_dm
    output logic [0:0]   o_m_axis_tuser    // [0] k_infinite
);
    import ceagm_pkg::*;

    t_dp_op            w_op;
    t_dp_stat          w_stat;
    logic [31:0]       w_k;
    logic [31:0]       w_e;
    logic [47:0]       w_dk;
    logic signed [31:0] w_de;
    logic              w_inf;

    ceagm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_op       (w_op)
    );

    ceagm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_op),
        .i_param_m    (i_s_axis_tdata),
        .o_stat       (w_stat),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_k_value    (w_k),
        .o_e_value    (w_e),
        .o_dk_dm      (w_dk),
        .o_de_dm      (w_de),
        .o_k_infinite (w_inf)
    );

    assign o_m_axis_tdata = {w_de, w_dk, w_e, w_k};
    assign o_m_axis_tuser = w_inf;
endmodule

FILE: hdl/ceagm_sqrt.sv
// ---------------------------------------------------------------------------
// ceagm_sqrt
// Floor square root of a 64-bit word, one result bit per cycle.
// ---------------------------------------------------------------------------
module ceagm_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_x;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [35:0] w_t;
    logic [35:0] w_trial;
    logic        w_ge;

    assign w_t     = {r_rem, r_x[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_t >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[61:0], 2'b00};
            r_rem  <= w_ge ? 34'(w_t - w_trial) : 34'(w_t);
            r_root <= {r_root[30:0], w_ge};
            r_cnt  <= r_cnt + 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

FILE: hdl/ceagm_div.sv
// ---------------------------------------------------------------------------
// ceagm_div
// Restoring divider: floor(num * 2^shift / den), saturated at a limit.
// ---------------------------------------------------------------------------
module ceagm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    input  logic [6:0]  i_shift,
    input  logic [63:0] i_max,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [63:0] r_max;
    logic [63:0] r_rem;
    logic [63:0] r_q;
    logic        r_ovf;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_t;
    logic        w_ge;

    assign w_t  = {r_rem, r_num[63]};
    assign w_ge = (w_t >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 7'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_max <= i_max;
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
            r_cnt <= 7'd63 + i_shift;
        end else if (r_busy) begin
            r_num <= {r_num[62:0], 1'b0};
            r_rem <= w_ge ? 64'(w_t - {1'b0, r_den}) : 64'(w_t);
            r_q   <= {r_q[62:0], w_ge};
            // a quotient bit pushed out means the limit is passed for good
            r_ovf <= r_ovf | r_q[63];
            r_cnt <= r_cnt - 7'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_den == '0 || r_ovf || r_q > r_max) ? r_max : r_q;
endmodule

FILE: hdl/ceagm_dp.sv
// ---------------------------------------------------------------------------
// ceagm_dp
// Datapath: AGM registers, shared 32x32 multiplier, square root and
// divider units, output register.
// ---------------------------------------------------------------------------
module ceagm_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ceagm_pkg::t_dp_op    i_op,
    input  logic signed [31:0]   i_param_m,
    output ceagm_pkg::t_dp_stat  o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_k_value,
    output logic [31:0]          o_e_value,
    output logic [47:0]          o_dk_dm,
    output logic signed [31:0]   o_de_dm,
    output logic                 o_k_infinite
);
    import ceagm_pkg::*;

    logic [29:0]     r_m;
    logic            r_inf;
    logic [31:0]     r_a;
    logic [31:0]     r_b;
    logic [29:0]     r_c;
    logic [62:0]     r_sum;
    logic [N_W-1:0]  r_n;
    logic [31:0]     r_oms;
    logic [63:0]     r_k;
    logic [32:0]     r_e;
    logic [32:0]     r_omk;
    logic [63:0]     r_prod;
    logic [63:0]     r_plo;
    logic [31:0]     r_pk;
    logic [31:0]     r_pe;
    logic [47:0]     r_dk;
    logic [31:0]     r_de;
    logic            r_out_valid;
    logic [31:0]     r_out_k;
    logic [31:0]     r_out_e;
    logic [47:0]     r_out_dk;
    logic [31:0]     r_out_de;
    logic            r_out_inf;

    logic [31:0]     w_mx;
    logic [31:0]     w_my;
    logic [63:0]     w_prod;
    logic [30:0]     w_omm31;
    logic [31:0]     w_om31;
    logic [N_W-1:0]  w_sh;
    logic [62:0]     w_lim;
    logic [63:0]     w_add;
    logic [62:0]     w_sum_n;
    logic [95:0]     w_full;
    logic [32:0]     w_ms;
    logic [10:0]     w_m11;
    logic [21:0]     w_msq;
    logic [63:0]     w_m62;
    logic [63:0]     w_m2;
    logic [63:0]     w_pk;
    logic [63:0]     w_pe;
    logic            w_sq_start;
    logic [63:0]     w_sq_in;
    logic            w_sq_done;
    logic [31:0]     w_root;
    logic            w_dv_start;
    logic [63:0]     w_dv_num;
    logic [63:0]     w_dv_den;
    logic [6:0]      w_dv_shift;
    logic [63:0]     w_dv_max;
    logic            w_dv_done;
    logic [63:0]     w_quot;

    assign w_omm31 = 31'h4000_0000 - {1'b0, r_m};
    assign w_om31  = {w_omm31, 1'b0};

    // shared multiplier operands
    always_comb begin
        w_mx = '0;
        w_my = '0;
        case (i_op)
            OP_AB:       begin w_mx = r_a;            w_my = r_b;              end
            OP_SQ_START: begin w_mx = {2'b00, r_c};   w_my = {2'b00, r_c};     end
            OP_E_LO:     begin w_mx = r_k[31:0];      w_my = r_oms;            end
            OP_E_HI:     begin w_mx = r_k[63:32];     w_my = r_oms;            end
            OP_OMK_LO:   begin w_mx = r_k[31:0];      w_my = w_om31;           end
            OP_OMK_HI:   begin w_mx = r_k[63:32];     w_my = w_om31;           end
            OP_DEN:      begin w_mx = {2'b00, r_m};   w_my = {1'b0, w_omm31};  end
            OP_SER1:     begin w_mx = HALF_PI_Q31;    w_my = r_pk;             end
            OP_SER2:     begin w_mx = HALF_PI_Q31;    w_my = r_pe;             end
            default:     begin w_mx = '0;             w_my = '0;               end
        endcase
    end
    assign w_prod = w_mx * w_my;

    // series sum update, r_prod holds c squared
    assign w_sh    = r_n - N_W'(1);
    assign w_lim   = ONE_Q62 >> w_sh;
    assign w_add   = {1'b0, r_sum} + (r_prod << w_sh);
    assign w_sum_n = (r_prod > {1'b0, w_lim} || w_add > {1'b0, ONE_Q62}) ?
                     ONE_Q62 : w_add[62:0];

    // 64 x 32 product from two partials, saturated as a Q.31 result
    assign w_full = {r_prod, 32'd0} + {32'd0, r_plo};
    assign w_ms   = (w_full[95:64] != 32'd0) ? '1 : w_full[63:31];

    // truncated hypergeometric series terms for small m
    assign w_m11 = r_m[10:0];
    assign w_msq = w_m11 * w_m11;
    assign w_m62 = {21'd0, w_m11, 32'd0};
    assign w_m2  = {40'd0, w_msq, 2'b00};
    assign w_pk  = QUARTER_Q62 + ((64'd9 * w_m62) >> 5) + ((64'd75 * w_m2) >> 8);
    assign w_pe  = QUARTER_Q62 + ((64'd3 * w_m62) >> 5) + ((64'd15 * w_m2) >> 8);

    assign w_sq_start = (i_op == OP_B0_START) || (i_op == OP_SQ_START);
    assign w_sq_in    = (i_op == OP_B0_START) ? {1'b0, w_omm31, 32'd0} : r_prod;

    always_comb begin
        w_dv_start = 1'b0;
        w_dv_num   = PI_Q61;
        w_dv_den   = {32'd0, r_a};
        w_dv_shift = NO_SHIFT;
        w_dv_max   = QUOT_MAX;
        case (i_op)
            OP_K_START: begin
                w_dv_start = 1'b1;
            end
            OP_DK_START: begin
                w_dv_start = 1'b1;
                w_dv_num   = (r_e > r_omk) ? {31'd0, r_e - r_omk} : '0;
                w_dv_den   = {r_prod[60:0], 3'b000};
                w_dv_shift = DK_SHIFT;
                w_dv_max   = DK_MAX;
            end
            OP_DE_START: begin
                w_dv_start = 1'b1;
                w_dv_num   = (r_k > {31'd0, r_e}) ? r_k - {31'd0, r_e} : '0;
                w_dv_den   = {32'd0, r_m, 2'b00};
                w_dv_shift = DE_SHIFT;
                w_dv_max   = DE_MAG_MAX;
            end
            default: begin
                w_dv_start = 1'b0;
            end
        endcase
    end

    ceagm_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (w_sq_in),
        .o_done     (w_sq_done),
        .o_root     (w_root)
    );

    ceagm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (w_dv_num),
        .i_den   (w_dv_den),
        .i_shift (w_dv_shift),
        .i_max   (w_dv_max),
        .o_done  (w_dv_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        case (i_op) inside
            OP_AB, OP_SQ_START, OP_E_LO, OP_E_HI, OP_OMK_LO, OP_OMK_HI, OP_DEN,
            OP_SER1, OP_SER2: begin
                r_prod <= w_prod;
            end
            default: begin
            end
        endcase
        case (i_op)
            OP_LOAD: begin
                r_inf <= !i_param_m[31] && i_param_m[30];
                r_m   <= i_param_m[31] ? '0 : i_param_m[29:0];
            end
            OP_B0_START: begin
                r_a   <= 32'h8000_0000;
                r_sum <= {2'b00, r_m, 31'd0};
                r_n   <= N_W'(1);
            end
            OP_B0_SET: r_b <= w_root;
            OP_AB: begin
                r_a <= 32'(({1'b0, r_a} + {1'b0, r_b}) >> 1);
                r_c <= (r_a > r_b) ? 30'((r_a - r_b) >> 1) : '0;
            end
            OP_SQ_SET: begin
                r_b   <= w_root;
                r_sum <= w_sum_n;
                r_n   <= r_n + N_W'(1);
            end
            OP_K_START: r_oms <= 32'(({1'b0, ONE_Q62} - {1'b0, r_sum}) >> 31);
            OP_K_SET:   r_k   <= w_quot;
            OP_E_HI:    r_plo <= r_prod;
            OP_E_SET:   r_e   <= w_ms;
            OP_OMK_HI:  r_plo <= r_prod;
            OP_OMK_SET: r_omk <= w_ms;
            OP_SER0: begin
                r_pk <= w_pk[62:31];
                r_pe <= w_pe[62:31];
            end
            OP_SER2:    r_dk <= {22'd0, r_prod[63:38]};
            OP_SER3:    r_de <= {2'b00, r_prod[63:34]};
            OP_DK_SET:  r_dk <= w_quot[47:0];
            OP_DE_SET:  r_de <= w_quot[31:0];
            OP_OUT: begin
                r_out_inf <= r_inf;
                r_out_k   <= r_inf ? 32'hFFFF_FFFF : r_k[38:7];
                r_out_e   <= r_inf ? 32'h4000_0000 : r_e[32:1];
                r_out_dk  <= r_inf ? DK_MAX[47:0] : r_dk;
                r_out_de  <= r_inf ? 32'h8000_0000 : 32'd0 - r_de;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.inf        = r_inf;
    assign o_stat.series     = (r_m < SERIES_LIMIT);
    assign o_stat.last_round = (r_c == '0) || (r_n == N_W'(AGM_ITERATIONS - 1));
    assign o_stat.sqrt_done  = w_sq_done;
    assign o_stat.div_done   = w_dv_done;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_k_value    = r_out_k;
    assign o_e_value    = r_out_e;
    assign o_dk_dm      = r_out_dk;
    assign o_de_dm      = r_out_de;
    assign o_k_infinite = r_out_inf;
endmodule

FILE: hdl/ceagm_ctrl.sv
// ---------------------------------------------------------------------------
// ceagm_ctrl
// Sequencer: steps the datapath through load, AGM rounds, K and E,
// derivatives and output.
// ---------------------------------------------------------------------------
module ceagm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ceagm_pkg::t_dp_stat  i_stat,
    output ceagm_pkg::t_dp_op    o_op
);
    import ceagm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_CHECK;
            ST_CHECK:    n_state = i_stat.inf ? ST_OUT : ST_B0_START;
            ST_B0_START: n_state = ST_B0_WAIT;
            ST_B0_WAIT:  if (i_stat.sqrt_done) n_state = ST_AB;
            ST_AB:       n_state = ST_SQ_START;
            ST_SQ_START: n_state = ST_SQ_WAIT;
            ST_SQ_WAIT: begin
                if (i_stat.sqrt_done) n_state = i_stat.last_round ? ST_K_START : ST_AB;
            end
            ST_K_START:  n_state = ST_K_WAIT;
            ST_K_WAIT:   if (i_stat.div_done) n_state = ST_E_LO;
            ST_E_LO:     n_state = ST_E_HI;
            ST_E_HI:     n_state = ST_E_FIN;
            ST_E_FIN:    n_state = i_stat.series ? ST_SER0 : ST_OMK_LO;
            ST_SER0:     n_state = ST_SER1;
            ST_SER1:     n_state = ST_SER2;
            ST_SER2:     n_state = ST_SER3;
            ST_SER3:     n_state = ST_OUT;
            ST_OMK_LO:   n_state = ST_OMK_HI;
            ST_OMK_HI:   n_state = ST_OMK_FIN;
            ST_OMK_FIN:  n_state = ST_DEN;
            ST_DEN:      n_state = ST_DK_START;
            ST_DK_START: n_state = ST_DK_WAIT;
            ST_DK_WAIT:  if (i_stat.div_done) n_state = ST_DE_START;
            ST_DE_START: n_state = ST_DE_WAIT;
            ST_DE_WAIT:  if (i_stat.div_done) n_state = ST_OUT;
            ST_OUT:      if (i_stat.out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_op = OP_LOAD;
            end
            ST_CHECK:    o_op = OP_NONE;
            ST_B0_START: o_op = OP_B0_START;
            ST_B0_WAIT:  if (i_stat.sqrt_done) o_op = OP_B0_SET;
            ST_AB:       o_op = OP_AB;
            ST_SQ_START: o_op = OP_SQ_START;
            ST_SQ_WAIT:  if (i_stat.sqrt_done) o_op = OP_SQ_SET;
            ST_K_START:  o_op = OP_K_START;
            ST_K_WAIT:   if (i_stat.div_done) o_op = OP_K_SET;
            ST_E_LO:     o_op = OP_E_LO;
            ST_E_HI:     o_op = OP_E_HI;
            ST_E_FIN:    o_op = OP_E_SET;
            ST_SER0:     o_op = OP_SER0;
            ST_SER1:     o_op = OP_SER1;
            ST_SER2:     o_op = OP_SER2;
            ST_SER3:     o_op = OP_SER3;
            ST_OMK_LO:   o_op = OP_OMK_LO;
            ST_OMK_HI:   o_op = OP_OMK_HI;
            ST_OMK_FIN:  o_op = OP_OMK_SET;
            ST_DEN:      o_op = OP_DEN;
            ST_DK_START: o_op = OP_DK_START;
            ST_DK_WAIT:  if (i_stat.div_done) o_op = OP_DK_SET;
            ST_DE_START: o_op = OP_DE_START;
            ST_DE_WAIT:  if (i_stat.div_done) o_op = OP_DE_SET;
            ST_OUT:      if (i_stat.out_free) o_op = OP_OUT;
            default:     o_op = OP_NONE;
        endcase
    end
endmodule

FILE: hdl/ceagm_checker.sv
// ---------------------------------------------------------------------------
// ceagm_checker
// Port-level checks on the AGM block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ceagm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [31:0]  i_s_axis_tdata,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [143:0] o_m_axis_tdata,
    input logic [0:0]   o_m_axis_tuser
);
    // output valid is low in the cycle after reset is sampled
    `CEA_ASSERT_NR(a_rst_out, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

    // an infinite K comes with K saturated and E at one
    `CEA_ASSERT(a_inf_vals, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata[31:0] == 32'hFFFF_FFFF && o_m_axis_tdata[63:32] == 32'h4000_0000)

    // dE/dm is never positive
    `CEA_ASSERT(a_de_sign, i_clk, i_rst_n, o_m_axis_tvalid |-> o_m_axis_tdata[143] || o_m_axis_tdata[143:112] == 32'd0)

    // one item at a time: ready drops after an input beat
    `CEA_ASSERT(a_one_item, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)

    // hold a stalled result beat
    `CEA_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
endmodule

bind complete_elliptic_integrals_agm ceagm_checker u_ceagm_checker (.*);

FILE: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Stream-level test of complete_elliptic_integrals_agm. Each parameter beat
// is pushed through a bit-exact fixed-point predictor of the AGM recursion,
// and every result beat is compared field by field in arrival order.
// The stimulus starts with directed corner values, then random parameters
// in three idling phases, two with sender and receiver stalls, one without.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ceagm_pkg::*;

    typedef struct {
        bit [31:0] k_value;
        bit [31:0] e_value;
        bit [47:0] dk_dm;
        bit [31:0] de_dm;
        bit        k_infinite;
    } t_integrals;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [31:0]  i_s_axis_tdata;   // [31:0] param_m
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [143:0] o_m_axis_tdata;   // [31:0] k, [63:32] e, [111:64] dk_dm, [143:112] de_dm
    logic [0:0]   o_m_axis_tuser;   // [0] k_infinite

    t_integrals pending_integrals[$];
    int         send_idle_pct;
    int         recv_idle_pct;
    int         error_count;

    complete_elliptic_integrals_agm dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic bit [63:0] int_sqrt(bit [63:0] x);
        bit [63:0] r;
        bit [63:0] b;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit [63:0] mul_trunc(bit [63:0] x, bit [63:0] y, int s);
        bit [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        if (p[127:64] != 0) return {64{1'b1}} >> s;
        return p[63:0] >> s;
    endfunction

    function automatic bit [63:0] frac_div(bit [63:0] num, int shift, bit [63:0] den,
                                           bit [63:0] maxq);
        bit [63:0] q;
        bit [63:0] r;
        if (den == 0) return maxq;
        q = num / den;
        r = num % den;
        if (q > maxq) return maxq;
        for (int i = 0; i < shift; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
            if (q > maxq) return maxq;
        end
        return q;
    endfunction

    function automatic t_integrals predict_integrals(bit [31:0] raw);
        t_integrals res;
        bit [63:0] one62, m, a, b, c, an, bn, c2, sum, k31, e31, oms;
        bit [63:0] m62, m2, pk, pe, dk, de, m31, om31, omk, num, den, dnum;
        one62 = 64'd1 << 62;
        m = raw[31] ? 64'd0 : {32'd0, raw};
        if (m >= (64'd1 << 30)) begin
            res.k_value    = 32'hFFFF_FFFF;
            res.e_value    = 32'h4000_0000;
            res.dk_dm      = {48{1'b1}};
            res.de_dm      = 32'h8000_0000;
            res.k_infinite = 1'b1;
            return res;
        end
        a = 64'd1 << 31;
        b = int_sqrt(((64'd1 << 30) - m) << 32);
        sum = m << 31;
        for (int n = 1; n < AGM_ITERATIONS; n++) begin
            an = (a + b) >> 1;
            bn = int_sqrt(a * b);
            c = (a > b) ? ((a - b) >> 1) : 64'd0;
            a = an;
            b = bn;
            c2 = c * c;
            if (c2 > (one62 >> (n - 1))) begin
                sum = one62;
            end else begin
                sum = sum + (c2 << (n - 1));
                if (sum > one62) sum = one62;
            end
            if (c == 0) break;
        end
        k31 = (a != 0) ? PI_Q61 / a : {64{1'b1}};
        oms = (one62 - sum) >> 31;
        e31 = mul_trunc(k31, oms, 31);
        res.k_value    = k31[38:7];
        res.e_value    = e31[32:1];
        res.k_infinite = 1'b0;
        if (m < 64'(SERIES_LIMIT)) begin
            m62 = m << 32;
            m2  = (m * m) << 2;
            pk  = QUARTER_Q62 + ((64'd9 * m62) >> 5) + ((64'd75 * m2) >> 8);
            pe  = QUARTER_Q62 + ((64'd3 * m62) >> 5) + ((64'd15 * m2) >> 8);
            dk  = (64'(HALF_PI_Q31) * (pk >> 31)) >> 38;
            de  = (64'(HALF_PI_Q31) * (pe >> 31)) >> 34;
        end else begin
            m31  = m << 1;
            om31 = ((64'd1 << 30) - m) << 1;
            omk  = mul_trunc(om31, k31, 31);
            num  = (e31 > omk) ? e31 - omk : 64'd0;
            den  = 64'd2 * m31 * om31;
            dk   = frac_div(num, 55, den, DK_MAX);
            dnum = (k31 > e31) ? k31 - e31 : 64'd0;
            de   = frac_div(dnum, 28, 64'd2 * m31, DE_MAG_MAX);
        end
        res.dk_dm = dk[47:0];
        de = 64'd0 - de;
        res.de_dm = de[31:0];
        return res;
    endfunction

    // ---------------- result side ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_integrals want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_integrals.size() == 0) begin
                $error("result beat with no parameter outstanding");
                error_count++;
            end else begin
                want = pending_integrals.pop_front();
                if (o_m_axis_tdata[31:0] !== want.k_value) begin
                    $error("k_value: expected %h, got %h", want.k_value, o_m_axis_tdata[31:0]);
                    error_count++;
                end
                if (o_m_axis_tdata[63:32] !== want.e_value) begin
                    $error("e_value: expected %h, got %h", want.e_value,
                           o_m_axis_tdata[63:32]);
                    error_count++;
                end
                if (o_m_axis_tdata[111:64] !== want.dk_dm) begin
                    $error("dk_dm: expected %h, got %h", want.dk_dm, o_m_axis_tdata[111:64]);
                    error_count++;
                end
                if (o_m_axis_tdata[143:112] !== want.de_dm) begin
                    $error("de_dm: expected %h, got %h", want.de_dm,
                           o_m_axis_tdata[143:112]);
                    error_count++;
                end
                if (o_m_axis_tuser[0] !== want.k_infinite) begin
                    $error("k_infinite: expected %b, got %b", want.k_infinite,
                           o_m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // ---------------- parameter side ----------------
    task automatic send_param(input bit [31:0] m);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= m;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_integrals.push_back(predict_integrals(m));
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_integrals.size() != 0) @(posedge i_clk);
    endtask

    function automatic bit [31:0] random_param();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) return $urandom();
        if (pick < 40) return $urandom_range(2000);
        if (pick < 55) return 32'h4000_0000 - $urandom_range(4096);
        if (pick < 90) return $urandom_range(32'h3FFF_FFFF);
        return $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
    endfunction

    task automatic test_corner_params();
        bit [31:0] corners[] = '{32'h0, 32'h1, 32'd1073, 32'd1074, 32'd1075,
            32'h0000_0100, 32'h0000_1000, 32'h1000_0000, 32'h2000_0000,
            32'h3FFF_F000, 32'h3FFF_FFFF, 32'h4000_0000, 32'h4000_0001,
            32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
            32'h5555_5555, 32'h1555_5555};
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (corners[i]) send_param(corners[i]);
        // hold the sender until the block has emptied
        drain_results();
    endtask

    task automatic test_random_params(input int count, input int s_idle, input int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < count; i++) send_param(random_param());
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 32'd0;
        i_m_axis_tready = 1'b0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        error_count     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_params();
        test_random_params(510, 21, 72);
        test_random_params(510, 72, 21);
        test_random_params(510, 0, 0);
        drain_results();
        repeat (1000) @(posedge i_clk);

        if (error_count == 0) begin
            $display("** complete_elliptic_integrals_agm: PASSED **");
        end else begin
            $display("** complete_elliptic_integrals_agm: FAILED **");
        end
        $finish;
    end

    initial begin
        #400ms;
        $display("** complete_elliptic_integrals_agm: FAILED **");
        $finish;
    end
endmodule
